[design/sio_pkg.sv]
package sio_pkg;

  // access codes
  localparam logic OP_READ     = 1'b0;
  localparam logic OP_WRITE    = 1'b1;
  localparam logic PORT_INDEX  = 1'b0;
  localparam logic PORT_DATA   = 1'b1;

  // configuration port register select (paddr bit 2)
  localparam logic CFG_IDE_CHANNEL = 1'b0;
  localparam logic CFG_STRAP_BYTE  = 1'b1;

  // configuration register indexes
  localparam logic [7:0] REG_ID       = 8'h00;
  localparam logic [7:0] REG_STRAP    = 8'h02;
  localparam logic [7:0] REG_CFG3     = 8'h03;
  localparam logic [7:0] REG_FDC      = 8'h10;
  localparam logic [7:0] REG_FDC_AUX  = 8'h11;
  localparam logic [7:0] REG_LPT      = 8'h20;
  localparam logic [7:0] REG_LPT_AUX  = 8'h21;
  localparam logic [7:0] REG_UARTA    = 8'h30;
  localparam logic [7:0] REG_UARTA_AUX = 8'h31;
  localparam logic [7:0] REG_UARTB    = 8'h40;
  localparam logic [7:0] REG_UARTB_AUX = 8'h41;
  localparam logic [7:0] REG_IDE      = 8'h50;
  localparam logic [7:0] NUM_REGS     = 8'h51;

  // constant values
  localparam logic [7:0] ID_VALUE     = 8'hA0;
  localparam logic [7:0] HIGH_READ    = 8'hFF;
  localparam logic [7:0] STRAP_RESET  = 8'h40;

  // write masks
  localparam logic [7:0] MASK_STRAP_KEEP = 8'h78;
  localparam logic [7:0] MASK_STRAP_WR   = 8'h01;
  localparam logic [7:0] MASK_CFG3       = 8'hF8;
  localparam logic [7:0] MASK_FDC        = 8'h83;
  localparam logic [7:0] MASK_FDC_AUX    = 8'h0F;
  localparam logic [7:0] MASK_LPT        = 8'hEF;
  localparam logic [7:0] MASK_LPT_AUX    = 8'h2F;
  localparam logic [7:0] MASK_UART       = 8'h9F;
  localparam logic [7:0] MASK_UART_AUX   = 8'h1F;
  localparam logic [7:0] MASK_IDE        = 8'h07;

  // interrupt lines
  localparam logic [2:0] IRQ_3 = 3'd3;
  localparam logic [2:0] IRQ_4 = 3'd4;
  localparam logic [2:0] IRQ_5 = 3'd5;
  localparam logic [2:0] IRQ_7 = 3'd7;

  // fixed bases
  localparam logic [9:0] FDC_BASE_PRI = 10'h3F0;
  localparam logic [9:0] FDC_BASE_SEC = 10'h370;
  localparam logic [9:0] IDE_BASE_PRI = 10'h1F0;
  localparam logic [9:0] IDE_BASE_SEC = 10'h170;

  // register state
  typedef struct packed {
    logic [7:0] index;
    logic [1:0] ide_channel;
    logic [7:0] strap;
    logic [7:0] reg02;
    logic [7:0] reg03;
    logic [7:0] reg10;
    logic [7:0] reg11;
    logic [7:0] reg20;
    logic [7:0] reg21;
    logic [7:0] reg30;
    logic [7:0] reg31;
    logic [7:0] reg40;
    logic [7:0] reg41;
    logic [7:0] reg50;
    logic       lpt_latch;
  } regs_t;

  localparam regs_t REGS_RESET = '{
    index:       8'h00,
    ide_channel: 2'd0,
    strap:       STRAP_RESET,
    reg02:       STRAP_RESET,
    reg03:       8'h00,
    reg10:       8'h01,
    reg11:       8'h00,
    reg20:       8'h00,
    reg21:       8'h00,
    reg30:       8'h00,
    reg31:       8'h02,
    reg40:       8'h00,
    reg41:       8'h02,
    reg50:       8'h01,
    lpt_latch:   1'b0
  };

  // decoded function settings
  typedef struct packed {
    logic [9:0] fdc_base;
    logic [9:0] lpt_base;
    logic [2:0] lpt_irq;
    logic [9:0] uart_a_base;
    logic [2:0] uart_a_irq;
    logic       uart_a_fast_clock;
    logic [9:0] uart_b_base;
    logic [2:0] uart_b_irq;
    logic       uart_b_fast_clock;
    logic [9:0] ide_base;
  } funcs_t;

  // serial port base selection
  function automatic logic [9:0] uart_base(input logic [2:0] sel);
    logic [9:0] b;
    case (sel)
      3'd0:    b = 10'h3F8;
      3'd1:    b = 10'h2F8;
      3'd2:    b = 10'h220;
      3'd3:    b = 10'h228;
      3'd4:    b = 10'h238;
      3'd5:    b = 10'h2E8;
      3'd6:    b = 10'h338;
      default: b = 10'h3E8;
    endcase
    return b;
  endfunction

  // parallel port base selection
  function automatic logic [9:0] lpt_base(input logic [1:0] sel);
    logic [9:0] b;
    case (sel)
      2'd0:    b = 10'h378;
      2'd1:    b = 10'h278;
      2'd2:    b = 10'h3BC;
      default: b = 10'h000;
    endcase
    return b;
  endfunction

endpackage

[design/sio_regs.sv]
module sio_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              acc_en_i,
  input  logic              opcode_i,
  input  logic              port_select_i,
  input  logic [7:0]        write_data_i,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output logic [7:0]        read_data_o,
  output logic [2:0]        reset_pulses_o,
  output sio_pkg::regs_t    regs_d_o
);

  sio_pkg::regs_t regs_q;
  sio_pkg::regs_t regs_d;
  logic           cfg_wr;
  logic [7:0]     reg_rd;
  logic [7:0]     wd;
  logic           rise2;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign wd     = write_data_i;

  // configuration port read
  always_comb begin
    if (paddr[2] == sio_pkg::CFG_IDE_CHANNEL) begin
      prdata = {30'd0, regs_q.ide_channel};
    end else begin
      prdata = {24'd0, regs_q.strap};
    end
  end

  // indexed register read
  always_comb begin
    unique case (regs_q.index)
      sio_pkg::REG_ID:        reg_rd = sio_pkg::ID_VALUE;
      sio_pkg::REG_STRAP:     reg_rd = regs_q.reg02;
      sio_pkg::REG_CFG3:      reg_rd = regs_q.reg03;
      sio_pkg::REG_FDC:       reg_rd = regs_q.reg10;
      sio_pkg::REG_FDC_AUX:   reg_rd = regs_q.reg11;
      sio_pkg::REG_LPT:       reg_rd = regs_q.reg20;
      sio_pkg::REG_LPT_AUX:   reg_rd = regs_q.reg21;
      sio_pkg::REG_UARTA:     reg_rd = regs_q.reg30;
      sio_pkg::REG_UARTA_AUX: reg_rd = regs_q.reg31;
      sio_pkg::REG_UARTB:     reg_rd = regs_q.reg40;
      sio_pkg::REG_UARTB_AUX: reg_rd = regs_q.reg41;
      sio_pkg::REG_IDE:       reg_rd = regs_q.reg50;
      default: begin
        reg_rd = (regs_q.index < sio_pkg::NUM_REGS) ? 8'h00 : sio_pkg::HIGH_READ;
      end
    endcase
  end

  // read data of the access, zero on writes
  always_comb begin
    if (opcode_i == sio_pkg::OP_WRITE) begin
      read_data_o = 8'h00;
    end else if (port_select_i == sio_pkg::PORT_INDEX) begin
      read_data_o = regs_q.index;
    end else begin
      read_data_o = reg_rd;
    end
  end

  // next register state and reset pulses
  always_comb begin
    regs_d         = regs_q;
    reset_pulses_o = 3'd0;
    rise2          = 1'b0;
    if (cfg_wr) begin
      if (paddr[2] == sio_pkg::CFG_IDE_CHANNEL) begin
        regs_d.ide_channel = pwdata[1:0];
      end else begin
        regs_d.strap = pwdata[7:0];
        regs_d.reg02 = pwdata[7:0];
      end
    end else if (acc_en_i && opcode_i == sio_pkg::OP_WRITE) begin
      if (port_select_i == sio_pkg::PORT_INDEX) begin
        regs_d.index = wd;
      end else begin
        unique case (regs_q.index)
          sio_pkg::REG_STRAP: begin
            regs_d.reg02 = (regs_q.reg02 & sio_pkg::MASK_STRAP_KEEP) |
                           (wd & sio_pkg::MASK_STRAP_WR);
          end
          sio_pkg::REG_CFG3: regs_d.reg03 = wd & sio_pkg::MASK_CFG3;
          sio_pkg::REG_FDC:  regs_d.reg10 = wd & sio_pkg::MASK_FDC;
          sio_pkg::REG_FDC_AUX: begin
            regs_d.reg11 = wd & sio_pkg::MASK_FDC_AUX;
            rise2 = ~regs_q.reg11[2] & wd[2];
            reset_pulses_o = {2'b00, rise2};
          end
          sio_pkg::REG_LPT: begin
            regs_d.reg20 = wd & sio_pkg::MASK_LPT;
            // latch follows bit 3 only when bits 2:0 (enable and base select) change
            if ((regs_q.reg20[2:0] ^ wd[2:0]) != 3'd0) begin
              regs_d.lpt_latch = wd[3];
            end
          end
          sio_pkg::REG_LPT_AUX: regs_d.reg21 = wd & sio_pkg::MASK_LPT_AUX;
          sio_pkg::REG_UARTA:   regs_d.reg30 = wd & sio_pkg::MASK_UART;
          sio_pkg::REG_UARTA_AUX: begin
            regs_d.reg31 = wd & sio_pkg::MASK_UART_AUX;
            rise2 = ~regs_q.reg31[2] & wd[2];
            reset_pulses_o = {1'b0, rise2, 1'b0};
          end
          sio_pkg::REG_UARTB: regs_d.reg40 = wd & sio_pkg::MASK_UART;
          sio_pkg::REG_UARTB_AUX: begin
            regs_d.reg41 = wd & sio_pkg::MASK_UART_AUX;
            rise2 = ~regs_q.reg41[2] & wd[2];
            reset_pulses_o = {rise2, 2'b00};
          end
          sio_pkg::REG_IDE: regs_d.reg50 = wd & sio_pkg::MASK_IDE;
          default: ;
        endcase
      end
    end
  end

  assign regs_d_o = regs_d;

  // register state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= sio_pkg::REGS_RESET;
    end else begin
      regs_q <= regs_d;
    end
  end

endmodule

[design/sio_decode.sv]
module sio_decode (
  input  sio_pkg::regs_t  regs_i,
  output sio_pkg::funcs_t funcs_o
);

  // floppy, parallel, serial and ide decode
  always_comb begin
    funcs_o.fdc_base = regs_i.reg10[0] ?
      (regs_i.reg10[1] ? sio_pkg::FDC_BASE_SEC : sio_pkg::FDC_BASE_PRI) : 10'd0;

    funcs_o.lpt_base = regs_i.reg20[0] ? sio_pkg::lpt_base(regs_i.reg20[2:1]) : 10'd0;
    funcs_o.lpt_irq  = regs_i.lpt_latch ? sio_pkg::IRQ_7 : sio_pkg::IRQ_5;

    funcs_o.uart_a_base = regs_i.reg30[0] ? sio_pkg::uart_base(regs_i.reg30[3:1]) : 10'd0;
    funcs_o.uart_a_irq  = regs_i.reg30[4] ? sio_pkg::IRQ_4 : sio_pkg::IRQ_3;
    funcs_o.uart_a_fast_clock = regs_i.reg30[7];

    funcs_o.uart_b_base = regs_i.reg40[0] ? sio_pkg::uart_base(regs_i.reg40[3:1]) : 10'd0;
    funcs_o.uart_b_irq  = regs_i.reg40[4] ? sio_pkg::IRQ_4 : sio_pkg::IRQ_3;
    funcs_o.uart_b_fast_clock = regs_i.reg40[7];

    funcs_o.ide_base = ((regs_i.ide_channel != 2'd0) && regs_i.reg50[0]) ?
      (regs_i.reg50[1] ? sio_pkg::IDE_BASE_SEC : sio_pkg::IDE_BASE_PRI) : 10'd0;
  end

endmodule

[design/super_io_config_register_file_top.sv]
// Flow: an accepted item is held in the input register; the indexed registers
// and the result register take its access once the output can advance.
// Throughput: one item per cycle if not stalled; the input register, register
// update and result register form a two-stage pipeline (single access path).
// Reset: asynchronous, active low; pipeline empties, configuration registers
// and indexed registers return to their default values at once.
module super_io_config_register_file_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic        port_select_i,
  input  logic [7:0]  write_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  read_data_o,
  output logic [9:0]  fdc_base_o,
  output logic [9:0]  lpt_base_o,
  output logic [2:0]  lpt_irq_o,
  output logic [9:0]  uart_a_base_o,
  output logic [2:0]  uart_a_irq_o,
  output logic        uart_a_fast_clock_o,
  output logic [9:0]  uart_b_base_o,
  output logic [2:0]  uart_b_irq_o,
  output logic        uart_b_fast_clock_o,
  output logic [9:0]  ide_base_o,
  output logic [2:0]  reset_pulses_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic            s1_valid_q;
  logic            s1_opcode_q;
  logic            s1_port_q;
  logic [7:0]      s1_wdata_q;
  logic            out_valid_q;
  logic [7:0]      rd_data_q;
  logic [2:0]      pulses_q;
  sio_pkg::funcs_t funcs_q;
  logic            out_adv;
  logic            acc_en;
  logic            in_acc;
  logic [7:0]      rd_data;
  logic [2:0]      pulses;
  sio_pkg::regs_t  regs_d;
  sio_pkg::funcs_t funcs;

  // handshake
  assign out_adv    = ~out_valid_q | ~out_stall_i;
  assign acc_en     = s1_valid_q & out_adv;
  assign in_stall_o = s1_valid_q & ~out_adv;
  assign in_acc     = in_valid_i & ~in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (acc_en) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_opcode_q <= opcode_i;
      s1_port_q   <= port_select_i;
      s1_wdata_q  <= write_data_i;
    end
  end

  sio_regs u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .acc_en_i       (acc_en),
    .opcode_i       (s1_opcode_q),
    .port_select_i  (s1_port_q),
    .write_data_i   (s1_wdata_q),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .read_data_o    (rd_data),
    .reset_pulses_o (pulses),
    .regs_d_o       (regs_d)
  );

  // decode from the state after the access
  sio_decode u_decode (
    .regs_i  (regs_d),
    .funcs_o (funcs)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_en) begin
      rd_data_q <= rd_data;
      pulses_q  <= pulses;
      funcs_q   <= funcs;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign read_data_o         = rd_data_q;
  assign reset_pulses_o      = pulses_q;
  assign fdc_base_o          = funcs_q.fdc_base;
  assign lpt_base_o          = funcs_q.lpt_base;
  assign lpt_irq_o           = funcs_q.lpt_irq;
  assign uart_a_base_o       = funcs_q.uart_a_base;
  assign uart_a_irq_o        = funcs_q.uart_a_irq;
  assign uart_a_fast_clock_o = funcs_q.uart_a_fast_clock;
  assign uart_b_base_o       = funcs_q.uart_b_base;
  assign uart_b_irq_o        = funcs_q.uart_b_irq;
  assign uart_b_fast_clock_o = funcs_q.uart_b_fast_clock;
  assign ide_base_o          = funcs_q.ide_base;

endmodule
